[sv/i2ew_pkg.sv]
// Shared types and constants for the integer-to-English word token block.
// No dependencies; used by every module of the block.
`default_nettype none

package i2ew_pkg;

	// Input field width and decimal digit capacity of the converter
	localparam int VALUE_W    = 31;
	localparam int NUM_DIGITS = 10;
	localparam int BCD_W      = 4 * NUM_DIGITS;
	localparam int GRP_DIG_W  = 48;	// four groups of three digits
	localparam int WORD_W     = 5;

	// Word token codes
	localparam logic [WORD_W-1:0] TOK_ZERO      = 5'd0;
	localparam logic [WORD_W-1:0] TOK_TEN       = 5'd10;
	localparam logic [WORD_W-1:0] TOK_TENS_BASE = 5'd18;
	localparam logic [WORD_W-1:0] TOK_HUNDRED   = 5'd28;
	localparam logic [WORD_W-1:0] TOK_THOUSAND  = 5'd29;
	localparam logic [WORD_W-1:0] TOK_MILLION   = 5'd30;
	localparam logic [WORD_W-1:0] TOK_BILLION   = 5'd31;

	// Group index of the units group
	localparam logic [1:0] GRP_UNITS = 2'd3;

	// Queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Front converter states
	typedef enum logic [1:0] {
		F_IDLE,
		F_CONV,
		F_PUSH
	} front_state_t;

	// Back token sequencer states
	typedef enum logic [2:0] {
		B_IDLE,
		B_ZERO,
		B_HUND_DIGIT,
		B_HUND_WORD,
		B_TENS,
		B_ONES,
		B_SCALE
	} back_state_t;

endpackage

`default_nettype wire

[sv/integer_to_english_word_tokens_top.sv]
// Top level of the integer-to-English word token block.
// Depends on i2ew_pkg, i2ew_front, i2ew_fifo and i2ew_back.
//
// Spells a non-negative integer as American English word tokens, most
// significant first, with last set on the final token; zero gives one token
// Zero. The input takes a new value only once the last one has been
// accepted, converted one bit per cycle by the shift-and-add-3 BCD
// converter and handed to a two-entry queue; the hand-over waits while the
// queue is full. The token sequencer behind the queue runs on its own and
// gives at most one token per cycle, waiting while the output is not taken;
// it needs fewer steps per value than the converter at the default width
// (a load, then steps for the tokens, the all-zero groups and the groups
// without a hundreds digit), so the converter sets the sustained rate.
// Value bits at and above VALUE_BITS are ignored.
`default_nettype none

module integer_to_english_word_tokens_top #(
	parameter int VALUE_BITS = 31
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [i2ew_pkg::VALUE_W-1:0]  value,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [i2ew_pkg::WORD_W-1:0]        word,
	output logic                               last
);

	logic                        push;
	logic                        pop;
	logic [i2ew_pkg::BCD_W-1:0]  bcd;
	logic [i2ew_pkg::BCD_W-1:0]  rdata;
	i2ew_pkg::q_stat_t           q_stat;

	i2ew_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.value    (value),
		.push     (push),
		.q_stat   (q_stat),
		.bcd      (bcd)
	);

	i2ew_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (bcd),
		.pop    (pop),
		.rdata  (rdata),
		.q_stat (q_stat)
	);

	i2ew_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.rdata     (rdata),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.word      (word),
		.last      (last)
	);

endmodule

`default_nettype wire

[sv/i2ew_front.sv]
// Front part: accepts a value and converts it to BCD by shift-and-add-3.
// Depends on i2ew_pkg.
`default_nettype none

module i2ew_front #(
	parameter int VALUE_BITS = 31
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [i2ew_pkg::VALUE_W-1:0]  value,
	output logic                               push,
	input  wire i2ew_pkg::q_stat_t             q_stat,
	output logic [i2ew_pkg::BCD_W-1:0]         bcd
);

	localparam int CNT_W = $clog2(VALUE_BITS + 1);

	i2ew_pkg::front_state_t state_q, state_d;
	logic [CNT_W-1:0]            cnt_q;
	logic [VALUE_BITS-1:0]       sh_q;
	logic [i2ew_pkg::BCD_W-1:0]  bcd_q;
	logic [i2ew_pkg::BCD_W-1:0]  bcd_adj;
	logic                        take;

	// Add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < i2ew_pkg::NUM_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			i2ew_pkg::F_IDLE: begin
				if (in_valid) begin
					state_d = i2ew_pkg::F_CONV;
				end
			end
			i2ew_pkg::F_CONV: begin
				if (cnt_q == CNT_W'(1)) begin
					state_d = i2ew_pkg::F_PUSH;
				end
			end
			i2ew_pkg::F_PUSH: begin
				if (!q_stat.full) begin
					state_d = i2ew_pkg::F_IDLE;
				end
			end
			default: state_d = i2ew_pkg::F_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready = 1'b0;
		push     = 1'b0;
		case (state_q)
			i2ew_pkg::F_IDLE: in_ready = 1'b1;
			i2ew_pkg::F_PUSH: push     = !q_stat.full;
			default: begin
				in_ready = 1'b0;
				push     = 1'b0;
			end
		endcase
	end

	assign take = in_valid && in_ready;
	assign bcd  = bcd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= i2ew_pkg::F_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (take) begin
				cnt_q <= CNT_W'(VALUE_BITS);
			end else if (state_q == i2ew_pkg::F_CONV) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// Datapath: load on transfer, one bit per cycle while converting
	always_ff @(posedge clk) begin
		if (take) begin
			sh_q  <= value[VALUE_BITS-1:0];
			bcd_q <= '0;
		end else if (state_q == i2ew_pkg::F_CONV) begin
			sh_q  <= {sh_q[VALUE_BITS-2:0], 1'b0};
			bcd_q <= {bcd_adj[i2ew_pkg::BCD_W-2:0], sh_q[VALUE_BITS-1]};
		end
	end

endmodule

`default_nettype wire

[sv/i2ew_fifo.sv]
// Two-entry queue of BCD values between the converter and the token sequencer.
// Depends on i2ew_pkg.
`default_nettype none

module i2ew_fifo (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	input  wire logic [i2ew_pkg::BCD_W-1:0]    wdata,
	input  wire logic                          pop,
	output logic [i2ew_pkg::BCD_W-1:0]         rdata,
	output i2ew_pkg::q_stat_t                  q_stat
);

	logic [i2ew_pkg::BCD_W-1:0] mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	assign q_stat.full  = (cnt_q == 2'd2);
	assign q_stat.empty = (cnt_q == 2'd0);
	assign rdata        = mem_q[rptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

`ifndef ASSERT_OFF
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("queue written while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("queue read while empty");
	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop && !q_stat.full) |=> (cnt_q == $past(cnt_q) + 2'd1))
		else $error("queue fill count lost a write");
`endif

endmodule

`default_nettype wire

[sv/i2ew_back.sv]
// Back part: walks the BCD groups and emits up to one word token per cycle.
// Depends on i2ew_pkg. Waits while the output is not taken.
`default_nettype none

module i2ew_back (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire i2ew_pkg::q_stat_t                   q_stat,
	input  wire logic [i2ew_pkg::BCD_W-1:0]          rdata,
	output logic                                     pop,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [i2ew_pkg::WORD_W-1:0]              word,
	output logic                                     last
);

	i2ew_pkg::back_state_t state_q, state_d;
	logic [1:0]                      grp_q;
	logic                            grp_inc;
	logic [i2ew_pkg::GRP_DIG_W-1:0]  dig_q;
	logic                            out_valid_q;
	logic [i2ew_pkg::WORD_W-1:0]     word_q;
	logic                            last_q;

	logic [11:0] grp_dig;
	logic [3:0]  h, t, o;
	logic        gz, rz, g3, low_zero, out_free;
	logic        emit, last_c;
	logic [i2ew_pkg::WORD_W-1:0] tok, scale_tok;

	// Current group digits and lower-group zero test
	always_comb begin
		case (grp_q)
			2'd0: begin
				grp_dig   = dig_q[47:36];
				low_zero  = (dig_q[35:0] == '0);
				scale_tok = i2ew_pkg::TOK_BILLION;
			end
			2'd1: begin
				grp_dig   = dig_q[35:24];
				low_zero  = (dig_q[23:0] == '0);
				scale_tok = i2ew_pkg::TOK_MILLION;
			end
			2'd2: begin
				grp_dig   = dig_q[23:12];
				low_zero  = (dig_q[11:0] == '0);
				scale_tok = i2ew_pkg::TOK_THOUSAND;
			end
			default: begin
				grp_dig   = dig_q[11:0];
				low_zero  = 1'b1;
				scale_tok = i2ew_pkg::TOK_ZERO;
			end
		endcase
	end

	assign h        = grp_dig[11:8];
	assign t        = grp_dig[7:4];
	assign o        = grp_dig[3:0];
	assign gz       = (grp_dig == '0);
	assign rz       = (t == 4'd0) && (o == 4'd0);
	assign g3       = (grp_q == i2ew_pkg::GRP_UNITS);
	assign out_free = !out_valid_q || out_ready;

	// Token outputs of the current step
	always_comb begin
		emit   = 1'b0;
		tok    = i2ew_pkg::TOK_ZERO;
		last_c = 1'b0;
		pop    = 1'b0;
		case (state_q)
			i2ew_pkg::B_IDLE: pop = !q_stat.empty;
			i2ew_pkg::B_ZERO: begin
				emit   = 1'b1;
				last_c = 1'b1;
			end
			i2ew_pkg::B_HUND_DIGIT: begin
				emit = !gz && (h != 4'd0);
				tok  = {1'b0, h};
			end
			i2ew_pkg::B_HUND_WORD: begin
				emit   = 1'b1;
				tok    = i2ew_pkg::TOK_HUNDRED;
				last_c = g3 && rz;
			end
			i2ew_pkg::B_TENS: begin
				emit = !rz;
				if (t >= 4'd2) begin
					tok    = i2ew_pkg::TOK_TENS_BASE + {1'b0, t};
					last_c = g3 && (o == 4'd0);
				end else begin
					// teen or single ones word
					tok    = (t == 4'd1) ? (i2ew_pkg::TOK_TEN + {1'b0, o}) : {1'b0, o};
					last_c = g3;
				end
			end
			i2ew_pkg::B_ONES: begin
				emit   = 1'b1;
				tok    = {1'b0, o};
				last_c = g3;
			end
			i2ew_pkg::B_SCALE: begin
				emit   = 1'b1;
				tok    = scale_tok;
				last_c = low_zero;
			end
			default: begin
				emit   = 1'b0;
				last_c = 1'b0;
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		grp_inc = 1'b0;
		case (state_q)
			i2ew_pkg::B_IDLE: begin
				if (!q_stat.empty) begin
					state_d = (rdata == '0) ? i2ew_pkg::B_ZERO : i2ew_pkg::B_HUND_DIGIT;
				end
			end
			i2ew_pkg::B_ZERO: begin
				if (out_free) begin
					state_d = i2ew_pkg::B_IDLE;
				end
			end
			i2ew_pkg::B_HUND_DIGIT: begin
				if (gz) begin
					state_d = g3 ? i2ew_pkg::B_IDLE : i2ew_pkg::B_HUND_DIGIT;
					grp_inc = !g3;
				end else if (h == 4'd0) begin
					state_d = i2ew_pkg::B_TENS;
				end else if (out_free) begin
					state_d = i2ew_pkg::B_HUND_WORD;
				end
			end
			i2ew_pkg::B_HUND_WORD: begin
				if (out_free) begin
					if (!rz) begin
						state_d = i2ew_pkg::B_TENS;
					end else begin
						state_d = g3 ? i2ew_pkg::B_IDLE : i2ew_pkg::B_SCALE;
					end
				end
			end
			i2ew_pkg::B_TENS: begin
				if (rz) begin
					state_d = g3 ? i2ew_pkg::B_IDLE : i2ew_pkg::B_SCALE;
				end else if (out_free) begin
					if ((t >= 4'd2) && (o != 4'd0)) begin
						state_d = i2ew_pkg::B_ONES;
					end else begin
						state_d = g3 ? i2ew_pkg::B_IDLE : i2ew_pkg::B_SCALE;
					end
				end
			end
			i2ew_pkg::B_ONES: begin
				if (out_free) begin
					state_d = g3 ? i2ew_pkg::B_IDLE : i2ew_pkg::B_SCALE;
				end
			end
			i2ew_pkg::B_SCALE: begin
				if (out_free) begin
					state_d = low_zero ? i2ew_pkg::B_IDLE : i2ew_pkg::B_HUND_DIGIT;
					grp_inc = !low_zero;
				end
			end
			default: state_d = i2ew_pkg::B_IDLE;
		endcase
	end

	// Control registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= i2ew_pkg::B_IDLE;
			grp_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				grp_q <= 2'd0;
			end else if (grp_inc) begin
				grp_q <= grp_q + 2'd1;
			end
			if (out_free) begin
				out_valid_q <= emit;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (pop) begin
			dig_q <= {{(i2ew_pkg::GRP_DIG_W - i2ew_pkg::BCD_W){1'b0}}, rdata};
		end
		if (out_free) begin
			word_q <= tok;
			last_q <= last_c;
		end
	end

	assign out_valid = out_valid_q;
	assign word      = word_q;
	assign last      = last_q;

`ifndef ASSERT_OFF
	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && out_free && last_c) |=> (state_q == i2ew_pkg::B_IDLE))
		else $error("last token emitted but sequencer kept going");
	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && out_free && !last_c) |=> (state_q != i2ew_pkg::B_IDLE))
		else $error("sequencer finished without a last token");
	a_load_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (grp_q == 2'd0) && (state_q != i2ew_pkg::B_IDLE))
		else $error("queue entry taken but no run started");
`endif

endmodule

`default_nettype wire
